[rtl/core/hpps_pkg.sv]
// shared types, widths and constants of the haptic pulse phase sequencer
package hpps_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned DIVR_W  = 8;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'd0;
  localparam logic [DUR_W-1:0]   LONG_MS    = 16'd10;
  localparam logic [TIME_W-1:0]  RECENT_MS  = 32'd200;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_DIVISOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_MAX_MS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DIVISOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_MAX_MS  = 3'd4;

  // register reset values
  localparam logic [LEVEL_W-1:0] RST_FORWARD_LEVEL = 8'd255;
  localparam logic [DIVR_W-1:0]  RST_DIVISOR       = 8'd4;
  localparam logic [DUR_W-1:0]   RST_MAX_MS        = 16'd50;

  typedef enum logic [1:0] {
    PH_ASLEEP  = 2'd0,
    PH_FORWARD = 2'd1,
    PH_REVERSE = 2'd2,
    PH_BRAKE   = 2'd3
  } phase_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic tick_inc;
    logic tick_step;
    logic damp;
    logic div_start;
    logic div_rev;
    logic cap_brake;
    logic cap_rev;
    logic start_pulse;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_req;
    logic asleep;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/hpps_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
module hpps_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hpps_pkg::DUR_W-1:0] dividend_i,
  input  logic [hpps_pkg::DIVR_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [hpps_pkg::DUR_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(hpps_pkg::DUR_W + 1);

  logic [hpps_pkg::DUR_W-1:0]  quo_q, quo_d;
  logic [hpps_pkg::DIVR_W-1:0] rem_q, rem_d;
  logic [hpps_pkg::DIVR_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic [hpps_pkg::DIVR_W:0]   trial;
  logic                        ge;

  assign trial = {rem_q, quo_q[hpps_pkg::DUR_W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(hpps_pkg::DUR_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = hpps_pkg::DIVR_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[hpps_pkg::DIVR_W-1:0];
      end
      quo_d = {quo_q[hpps_pkg::DUR_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

[rtl/core/hpps_dp.sv]
// datapath: registers, timing state, phase split arithmetic and result register
module hpps_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [hpps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hpps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            action_i,
  input  logic [hpps_pkg::DUR_W-1:0]      duration_ms_i,
  input  logic                            fault_active_i,
  input  hpps_pkg::cmd_t                  cmd_i,
  output hpps_pkg::sts_t                  sts_o,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [hpps_pkg::LEVEL_W-1:0]    level_a_o,
  output logic [hpps_pkg::LEVEL_W-1:0]    level_b_o,
  output logic [1:0]                      phase_o
);

  localparam int unsigned TW = hpps_pkg::TIME_W;
  localparam int unsigned DW = hpps_pkg::DUR_W;
  localparam int unsigned LW = hpps_pkg::LEVEL_W;
  localparam int unsigned VW = hpps_pkg::DIVR_W;

  // configuration
  logic [LW-1:0] fwd_level_q;
  logic [VW-1:0] brake_div_q, rev_div_q;
  logic [DW-1:0] brake_max_q, rev_max_q;

  // timing state
  logic [TW-1:0] now_q, end_q, last_q;
  hpps_pkg::phase_e phase_q;
  logic [DW-1:0] rev_time_q, brake_time_q;
  logic [LW-1:0] held_a_q, held_b_q;

  // latched item
  logic          action_q, fault_q;
  logic [DW-1:0] d_q;

  // result register
  logic          out_valid_q;
  logic [LW-1:0] out_a_q, out_b_q;
  logic [1:0]    out_ph_q;

  logic [TW-1:0] since_done;
  logic          recent;
  logic [VW-1:0] div_sel, div_eff;
  logic          div_busy;
  logic [DW-1:0] quo, cap_max, capped;
  logic          step_due;
  logic [LW-1:0] fwd_a;

  assign since_done = now_q - last_q;
  assign recent     = (since_done < hpps_pkg::RECENT_MS);

  assign div_sel = cmd_i.div_rev ? rev_div_q : brake_div_q;
  assign div_eff = (div_sel == '0) ? VW'(1) : div_sel;

  hpps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (d_q),
    .divisor_i  (div_eff),
    .busy_o     (div_busy),
    .quo_o      (quo)
  );

  assign cap_max  = cmd_i.cap_rev ? rev_max_q : brake_max_q;
  assign capped   = (quo > cap_max) ? cap_max : quo;
  assign step_due = (phase_q != hpps_pkg::PH_ASLEEP) && (now_q >= end_q);
  assign fwd_a    = fault_q ? hpps_pkg::LEVEL_OFF : fwd_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_level_q <= hpps_pkg::RST_FORWARD_LEVEL;
      brake_div_q <= hpps_pkg::RST_DIVISOR;
      brake_max_q <= hpps_pkg::RST_MAX_MS;
      rev_div_q   <= hpps_pkg::RST_DIVISOR;
      rev_max_q   <= hpps_pkg::RST_MAX_MS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hpps_pkg::CFG_FORWARD_LEVEL:   fwd_level_q <= cfg_data_i[LW-1:0];
        hpps_pkg::CFG_BRAKE_DIVISOR:   brake_div_q <= cfg_data_i[VW-1:0];
        hpps_pkg::CFG_BRAKE_MAX_MS:    brake_max_q <= cfg_data_i[DW-1:0];
        hpps_pkg::CFG_REVERSE_DIVISOR: rev_div_q   <= cfg_data_i[VW-1:0];
        hpps_pkg::CFG_REVERSE_MAX_MS:  rev_max_q   <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      end_q        <= '0;
      last_q       <= '0;
      phase_q      <= hpps_pkg::PH_ASLEEP;
      rev_time_q   <= '0;
      brake_time_q <= '0;
      held_a_q     <= '0;
      held_b_q     <= '0;
    end else begin
      if (cmd_i.tick_inc) begin
        now_q <= now_q + TW'(1);
      end
      if (cmd_i.cap_brake) begin
        brake_time_q <= capped;
      end
      if (cmd_i.cap_rev) begin
        rev_time_q <= capped;
      end
      if (cmd_i.start_pulse) begin
        end_q    <= now_q + TW'(d_q);
        phase_q  <= hpps_pkg::PH_FORWARD;
        held_a_q <= fwd_a;
        held_b_q <= hpps_pkg::LEVEL_OFF;
      end
      if (cmd_i.tick_step && step_due) begin
        case (phase_q)
          hpps_pkg::PH_FORWARD: begin
            end_q    <= now_q + TW'(rev_time_q);
            phase_q  <= hpps_pkg::PH_REVERSE;
            held_a_q <= hpps_pkg::LEVEL_OFF;
            held_b_q <= fault_q ? hpps_pkg::LEVEL_OFF : hpps_pkg::LEVEL_FULL;
          end
          hpps_pkg::PH_REVERSE: begin
            end_q    <= now_q + TW'(brake_time_q);
            phase_q  <= hpps_pkg::PH_BRAKE;
            held_a_q <= fault_q ? hpps_pkg::LEVEL_OFF : hpps_pkg::LEVEL_FULL;
            held_b_q <= fault_q ? hpps_pkg::LEVEL_OFF : hpps_pkg::LEVEL_FULL;
          end
          hpps_pkg::PH_BRAKE: begin
            last_q   <= now_q;
            phase_q  <= hpps_pkg::PH_ASLEEP;
            held_a_q <= hpps_pkg::LEVEL_OFF;
            held_b_q <= hpps_pkg::LEVEL_OFF;
          end
          default: ;
        endcase
      end
    end
  end

  // item and remaining duration
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q <= action_i;
      fault_q  <= fault_active_i;
      d_q      <= duration_ms_i;
    end else if (cmd_i.damp) begin
      if ((d_q > hpps_pkg::LONG_MS) && recent) begin
        d_q <= {1'b0, d_q[DW-1:1]} + DW'(1);
      end
    end else if (cmd_i.cap_brake || cmd_i.cap_rev) begin
      d_q <= d_q - capped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_a_q  <= held_a_q;
      out_b_q  <= held_b_q;
      out_ph_q <= phase_q;
    end
  end

  assign sts_o.is_req   = action_q;
  assign sts_o.asleep   = (phase_q == hpps_pkg::PH_ASLEEP);
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign level_a_o   = out_a_q;
  assign level_b_o   = out_b_q;
  assign phase_o     = out_ph_q;

endmodule

[rtl/core/hpps_ctrl.sv]
// controller state machine sequencing ticks, requests and result hand-off
module hpps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hpps_pkg::sts_t sts_i,
  output hpps_pkg::cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECODE = 11'b000_0000_0010,
    S_TSTEP  = 11'b000_0000_0100,
    S_BSTART = 11'b000_0000_1000,
    S_BWAIT  = 11'b000_0001_0000,
    S_BCAP   = 11'b000_0010_0000,
    S_RSTART = 11'b000_0100_0000,
    S_RWAIT  = 11'b000_1000_0000,
    S_RCAP   = 11'b001_0000_0000,
    S_FIN    = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts_i.is_req) begin
          cmd_o.tick_inc = 1'b1;
          state_d = S_TSTEP;
        end else if (!sts_i.asleep) begin
          state_d = S_OUT;
        end else begin
          cmd_o.damp = 1'b1;
          state_d = S_BSTART;
        end
      end
      S_TSTEP: begin
        cmd_o.tick_step = 1'b1;
        state_d = S_OUT;
      end
      S_BSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = S_BWAIT;
      end
      S_BWAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_BCAP;
        end
      end
      S_BCAP: begin
        cmd_o.cap_brake = 1'b1;
        state_d = S_RSTART;
      end
      S_RSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_rev   = 1'b1;
        state_d = S_RWAIT;
      end
      S_RWAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_RCAP;
        end
      end
      S_RCAP: begin
        cmd_o.cap_rev = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.start_pulse = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[rtl/core/haptic_pulse_phase_sequencer.sv]
// top level of the haptic pulse phase sequencer: controller plus datapath
// paths, input transfer to result transfer: a tick counts a ms and steps the phase,
//   ignored requests go straight out, pulse starts run two 16-step serial divisions
// throughput: one item at a time, next input transfer on the cycle after the result
//   is loaded; the result register lets the next item start while it waits
// reset: asynchronous active low; registers to defaults, phase asleep, ms count zero
module haptic_pulse_phase_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [hpps_pkg::DUR_W-1:0]      duration_ms_i,
  input  logic                            fault_active_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hpps_pkg::LEVEL_W-1:0]    level_a_o,
  output logic [hpps_pkg::LEVEL_W-1:0]    level_b_o,
  output logic [1:0]                      phase_o,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hpps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hpps_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  hpps_pkg::cmd_t cmd;
  hpps_pkg::sts_t sts;

  // registers take a write transfer on any cycle, held levels and timing state
  // start out zero with no result pending
  assign cfg_ready_o = 1'b1;

  // sequencing: idle -> decode -> tick step, split (divide, cap, divide, cap, start
  // forward) or nothing -> result load, waiting there only while a result is stalled
  hpps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath holds the millisecond clock, phase timing, held channel levels,
  // the shared serial divider and the result register
  hpps_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .duration_ms_i  (duration_ms_i),
    .fault_active_i (fault_active_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .level_a_o      (level_a_o),
    .level_b_o      (level_b_o),
    .phase_o        (phase_o)
  );

endmodule

[rtl/core/hpps_checker.sv]
// port-level checks of the haptic pulse phase sequencer and their bind
module hpps_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [hpps_pkg::LEVEL_W-1:0] level_a_o,
  input logic [hpps_pkg::LEVEL_W-1:0] level_b_o,
  input logic [1:0]                   phase_o
);

  // one item at a time: an accepted item makes the block busy
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(level_a_o) && $stable(level_b_o) && $stable(phase_o)))
    else $error("stalled result changed");

  // asleep always shows both channels off
  a_asleep_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (phase_o == hpps_pkg::PH_ASLEEP)) |->
      (level_a_o == hpps_pkg::LEVEL_OFF && level_b_o == hpps_pkg::LEVEL_OFF))
    else $error("levels on while asleep");

  // reverse drives only channel b, brake drives both alike
  a_reverse_brake_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (phase_o == hpps_pkg::PH_REVERSE || phase_o == hpps_pkg::PH_BRAKE)) |->
      ((phase_o == hpps_pkg::PH_REVERSE && level_a_o == hpps_pkg::LEVEL_OFF) ||
       (phase_o == hpps_pkg::PH_BRAKE && level_a_o == level_b_o)))
    else $error("wrong levels in reverse or brake");

endmodule

bind haptic_pulse_phase_sequencer hpps_checker u_hpps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .level_a_o   (level_a_o),
  .level_b_o   (level_b_o),
  .phase_o     (phase_o)
);
